// ===== hdl/fwna_pkg.sv =====
// Shared types and constants for the fixed-width number to ASCII formatter.
package fwna_pkg;

  // Operation codes
  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  localparam logic [1:0] OP_BIN  = 2'd3;

  // Widths fixed by the field definitions
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int DEC_DIGITS = 10;   // a 32-bit value has at most ten decimal digits
  localparam int HEX_DIGITS = 8;
  localparam int IDX_W     = 5;     // digit position 0..31
  localparam int DEC_IDX_W = 4;     // decimal digit position 0..9
  localparam int HEX_IDX_W = 3;     // hex digit position 0..7
  localparam int NUM_CELLS = VALUE_W; // one conversion cell per value bit

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_UPA   = 7'h41;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_TEN   = 7'd10;

  // Input transaction
  typedef struct packed {
    logic [1:0]         operation;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] digit_count;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } out_item_t;

  // Data carried along the conversion chain
  typedef struct packed {
    logic [1:0]                     op;
    logic [COUNT_W-1:0]             count;
    logic                           neg;
    logic [VALUE_W-1:0]             value;
    logic [DEC_DIGITS-1:0][3:0]     bcd;
  } cell_data_t;

endpackage

// ===== hdl/fwna_cell.sv =====
// One double-dabble cell: adjusts the BCD digits and shifts in one value bit.
module fwna_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic                  prev_vld,
  input  fwna_pkg::cell_data_t  prev_data,
  output logic                  cell_vld,
  output fwna_pkg::cell_data_t  cell_data
);

  logic                 vld_r;
  fwna_pkg::cell_data_t data_r;
  fwna_pkg::cell_data_t data_nxt;
  logic [fwna_pkg::DEC_DIGITS*4-1:0] adj;

  // Add three to every digit of five or more, then shift the value MSB in
  always_comb begin
    for (int d = 0; d < fwna_pkg::DEC_DIGITS; d++) begin
      adj[4*d +: 4] = (prev_data.bcd[d] >= 4'd5) ? prev_data.bcd[d] + 4'd3
                                                   : prev_data.bcd[d];
    end
    data_nxt       = prev_data;
    data_nxt.bcd   = {adj[fwna_pkg::DEC_DIGITS*4-2:0], prev_data.value[fwna_pkg::VALUE_W-1]};
    // rotate, so the value is back in place after the last cell
    data_nxt.value = {prev_data.value[fwna_pkg::VALUE_W-2:0],
                      prev_data.value[fwna_pkg::VALUE_W-1]};
  end

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= prev_vld;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= data_nxt;
    end
  end

  assign cell_vld  = vld_r;
  assign cell_data = data_r;

endmodule

// ===== hdl/fwna_serializer.sv =====
// Character serialiser: item to ASCII transactions, one per cycle unless stalled.
module fwna_serializer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  src_vld,
  input  fwna_pkg::cell_data_t  src_data,
  output logic                  ser_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fwna_pkg::out_item_t   out_data
);

  logic                          busy_r;
  logic                          sign_r;
  logic [fwna_pkg::IDX_W-1:0]    idx_r;
  fwna_pkg::cell_data_t          item_r;
  logic                          out_valid_r;
  fwna_pkg::out_item_t           out_data_r;

  logic                          emit;
  logic                          last_emit;
  logic                          load;
  logic [3:0]                    digit;
  fwna_pkg::out_item_t           char_nxt;

  assign emit      = busy_r && (!out_valid_r || !out_stall);
  assign last_emit = emit && !sign_r && (idx_r == '0);
  assign ser_free  = !busy_r || last_emit;
  assign load      = ser_free && src_vld;

  // Digit at the current position
  always_comb begin
    case (item_r.op)
      fwna_pkg::OP_HEX: digit = item_r.value[{idx_r[fwna_pkg::HEX_IDX_W-1:0], 2'b00} +: 4];
      fwna_pkg::OP_BIN: digit = {3'b000, item_r.value[idx_r]};
      default: begin
        if (idx_r < fwna_pkg::IDX_W'(fwna_pkg::DEC_DIGITS)) begin
          digit = item_r.bcd[idx_r[fwna_pkg::DEC_IDX_W-1:0]];
        end else begin
          digit = 4'd0;
        end
      end
    endcase
  end

  // Character code: sign first, then digits
  always_comb begin
    if (sign_r) begin
      char_nxt.char_code = item_r.neg ? fwna_pkg::CH_MINUS : fwna_pkg::CH_PLUS;
      char_nxt.last_char = 1'b0;
    end else begin
      if (digit < 4'd10) begin
        char_nxt.char_code = fwna_pkg::CH_ZERO + {3'b000, digit};
      end else begin
        char_nxt.char_code = fwna_pkg::CH_UPA + {3'b000, digit} - fwna_pkg::CH_TEN;
      end
      char_nxt.last_char = (idx_r == '0);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (last_emit) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item, position and output register
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= src_data;
      idx_r  <= fwna_pkg::IDX_W'(src_data.count - fwna_pkg::COUNT_W'(1));
      sign_r <= (src_data.op == fwna_pkg::OP_SDEC);
    end else if (emit) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else begin
        idx_r <= idx_r - fwna_pkg::IDX_W'(1);
      end
    end
    if (emit) begin
      out_data_r <= char_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/fixed_width_number_to_ascii.sv =====
// Fixed-width number to ASCII formatter: top level with the conversion chain.
//
// Input channel (in_valid/in_stall/in_data): one transaction per number, holding
// the operation (unsigned decimal, signed decimal, hex, binary), a 32-bit value
// and a digit count. The count is clamped to 1..10 decimal, 1..8 hex and
// 1..MAX_DIGITS binary.
// Output channel (out_valid/out_stall/out_data): one transaction per character,
// most significant first, leading zeros kept; signed decimal sends '+' or '-'
// first. last_char marks the final character of each number.
// The path from input transaction to first character runs through the 32-cell
// double-dabble chain (one value bit per cell), the serialiser load and the
// output register.
// Throughput: one character per cycle while the receiver does not stall; a
// number occupies the serialiser until its last character has been sent. The
// chain accepts a new number every cycle while it has room.
// Reset clears all valid flags; no number is in flight afterwards.
// When the receiver stalls, the output register holds its character, the chain
// freezes once its last cell holds a waiting number, and in_stall rises.
module fixed_width_number_to_ascii #(
  parameter int MAX_DIGITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fwna_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fwna_pkg::out_item_t  out_data
);

  localparam int DEC_MAX = (MAX_DIGITS < fwna_pkg::DEC_DIGITS) ? MAX_DIGITS : fwna_pkg::DEC_DIGITS;
  localparam int HEX_MAX = (MAX_DIGITS < fwna_pkg::HEX_DIGITS) ? MAX_DIGITS : fwna_pkg::HEX_DIGITS;
  localparam logic [fwna_pkg::COUNT_W-1:0] DEC_LIM = fwna_pkg::COUNT_W'(DEC_MAX);
  localparam logic [fwna_pkg::COUNT_W-1:0] HEX_LIM = fwna_pkg::COUNT_W'(HEX_MAX);
  localparam logic [fwna_pkg::COUNT_W-1:0] BIN_LIM = fwna_pkg::COUNT_W'(MAX_DIGITS);
  localparam int N = fwna_pkg::NUM_CELLS;

  logic                         advance;
  logic                         ser_free;
  logic                         neg;
  logic [fwna_pkg::COUNT_W-1:0] lim;
  fwna_pkg::cell_data_t         entry;
  logic                         cell_vld  [N];
  fwna_pkg::cell_data_t         cell_data [N];

  // Entry: clamp the count and take the magnitude for signed decimal
  always_comb begin
    case (in_data.operation)
      fwna_pkg::OP_HEX: lim = HEX_LIM;
      fwna_pkg::OP_BIN: lim = BIN_LIM;
      default:          lim = DEC_LIM;
    endcase
    neg         = (in_data.operation == fwna_pkg::OP_SDEC) &&
                  in_data.value[fwna_pkg::VALUE_W-1];
    entry.op    = in_data.operation;
    entry.neg   = neg;
    entry.value = neg ? (~in_data.value + fwna_pkg::VALUE_W'(1)) : in_data.value;
    entry.bcd   = '0;
    if (in_data.digit_count == '0) begin
      entry.count = fwna_pkg::COUNT_W'(1);
    end else if (in_data.digit_count > lim) begin
      entry.count = lim;
    end else begin
      entry.count = in_data.digit_count;
    end
  end

  // The whole chain moves unless its last cell waits on a busy serialiser
  assign advance  = !cell_vld[N-1] || ser_free;
  assign in_stall = !advance;

  // Conversion chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      fwna_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .prev_vld  (in_valid),
        .prev_data (entry),
        .cell_vld  (cell_vld[i]),
        .cell_data (cell_data[i])
      );
    end else begin : g_next
      fwna_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .prev_vld  (cell_vld[i-1]),
        .prev_data (cell_data[i-1]),
        .cell_vld  (cell_vld[i]),
        .cell_data (cell_data[i])
      );
    end
  end

  // Character output
  fwna_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_vld   (cell_vld[N-1]),
    .src_data  (cell_data[N-1]),
    .ser_free  (ser_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Input is held back only by a number waiting at the chain end
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> cell_vld[N-1])
    else $error("input stalled with no number waiting at chain end");

  // An accepted transaction enters the first cell
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> cell_vld[0])
    else $error("accepted transaction missing from first cell");

  // A frozen chain keeps its waiting number intact
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_vld[N-1] && !advance) |=> (cell_vld[N-1] && $stable(cell_data[N-1])))
    else $error("waiting number changed while chain was frozen");

endmodule
